// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

// ----- rtl/iee_pkg.sv -----
// ----------------------------------------------------------------------------
// iee_pkg
// Types, character codes and helpers of the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int DATA_W          = 32;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [2:0] {
		OPC_PAREN = 3'd0,
		OPC_ADD   = 3'd1,
		OPC_SUB   = 3'd2,
		OPC_MUL   = 3'd3,
		OPC_DIV   = 3'd4
	} op_code_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DIVZERO   = 2'd1,
		ST_MALFORMED = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef struct packed {
		logic                valid;
		op_code_t            op;
		logic [DATA_W-1:0]   a;
		logic [DATA_W-1:0]   b;
	} alu_req_t;

	typedef struct packed {
		logic                done;
		logic [DATA_W-1:0]   value;
	} alu_rsp_t;

	function automatic logic [1:0] prec(input op_code_t o);
		logic [1:0] p;
		case (o)
			OPC_ADD, OPC_SUB: p = 2'd1;
			OPC_MUL, OPC_DIV: p = 2'd2;
			default:          p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

// ----- rtl/iee_alu.sv -----
// ----------------------------------------------------------------------------
// iee_alu
// Shared arithmetic unit: add, subtract, multiply, and a one bit per cycle
// signed divide that truncates toward zero.
// ----------------------------------------------------------------------------
module iee_alu
	import iee_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	typedef enum logic {
		A_IDLE,
		A_DIV
	} alu_state_t;

	alu_state_t        state_q;
	logic              done_q;
	logic [DATA_W-1:0] result_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic              neg_q;
	logic [4:0]        cnt_q;

	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   rem_sub;
	logic [DATA_W-1:0] quo_nx;
	logic [DATA_W-1:0] rem_nx;

	always_comb begin
		rem_sh  = {rem_q, quo_q[DATA_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		if (!rem_sub[DATA_W]) begin
			rem_nx = rem_sub[DATA_W-1:0];
			quo_nx = {quo_q[DATA_W-2:0], 1'b1};
		end else begin
			rem_nx = rem_sh[DATA_W-1:0];
			quo_nx = {quo_q[DATA_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (req.valid) begin
						case (req.op)
							OPC_ADD: begin
								result_q <= req.a + req.b;
								done_q   <= 1'b1;
							end
							OPC_SUB: begin
								result_q <= req.a - req.b;
								done_q   <= 1'b1;
							end
							OPC_MUL: begin
								result_q <= req.a * req.b;
								done_q   <= 1'b1;
							end
							default: begin
								quo_q   <= req.a[DATA_W-1] ? -req.a : req.a;
								den_q   <= req.b[DATA_W-1] ? -req.b : req.b;
								neg_q   <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
								rem_q   <= '0;
								cnt_q   <= 5'd31;
								state_q <= A_DIV;
							end
						endcase
					end
				end
				A_DIV: begin
					quo_q <= quo_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						result_q <= neg_q ? -quo_nx : quo_nx;
						done_q   <= 1'b1;
						state_q  <= A_IDLE;
					end
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = result_q;

endmodule

// ----- rtl/infix_expression_evaluator_unit.sv -----
// A character holds the block once it is taken, and holds it longer for each
// reduction it causes and longer still for each division.
// The shared divide unit, one quotient bit per cycle, sets the worst case.
// Throughput: one character at a time; the next is taken when this one is done,
// and a last character also waits while an earlier result is still on offer.
// Reset clears the counts, the number accumulator and the error code at once.
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit
// Two-stack infix evaluator: a sequencer walks the value and operator stacks
// and drives one shared arithmetic unit.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_unit
	import iee_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_code,
	input  logic        is_last,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] value,
	output logic [1:0]  status
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// The sequencer visits a decode step, a dispatch step, and then a loop that
	// inspects the top operator and reduces while precedence demands it.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_DISPATCH,
		S_OP_WAIT,
		S_OP_TEST,
		S_RD_B,
		S_RD_A,
		S_EXEC,
		S_ALU_WAIT,
		S_END,
		S_FINAL,
		S_OUT_LOAD
	} state_t;

	// What the reduction loop is working towards.
	typedef enum logic [1:0] {
		M_CLOSE,
		M_OPER,
		M_FINAL
	} mode_t;

	state_t            state_q;
	mode_t             mode_q;
	logic [7:0]        char_q;
	logic              last_q;
	op_code_t          new_op_q;
	logic [CW-1:0]     vc_q;
	logic [CW-1:0]     oc_q;
	logic [DATA_W-1:0] accum_q;
	logic              pending_q;
	status_t           err_q;
	logic [DATA_W-1:0] b_q;
	logic              res_valid_q;
	logic [DATA_W-1:0] value_q;
	status_t           status_q;

	// Stack memories; they are read every cycle, but only entries below the counts are used.
	logic [DATA_W-1:0] val_mem [STACK_DEPTH];
	op_code_t          op_mem  [STACK_DEPTH];
	logic [DATA_W-1:0] val_rd_q;
	op_code_t          op_top_q;

	logic [CW-1:0]     vc_m1;
	logic [CW-1:0]     vc_m2;
	logic [CW-1:0]     oc_m1;
	logic [AW-1:0]     v_raddr;
	logic              v_we;
	logic [AW-1:0]     v_waddr;
	logic [DATA_W-1:0] v_wdata;
	logic              o_we;
	op_code_t          o_wdata;

	logic              is_digit;
	logic              flush_now;
	logic              val_full;
	logic              op_full;
	logic              do_reduce;
	logic [DATA_W-1:0] accum_nx;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	assign is_digit = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
	assign val_full = vc_q >= CW'(STACK_DEPTH);
	assign op_full  = oc_q >= CW'(STACK_DEPTH);
	assign vc_m1    = vc_q - CW'(1);
	assign vc_m2    = vc_q - CW'(2);
	assign oc_m1    = oc_q - CW'(1);
	assign accum_nx = (accum_q << 3) + (accum_q << 1) + {24'd0, char_q - CH_ZERO};

	// A pending number is pushed before any non-digit, and at the end.
	assign flush_now = (err_q == ST_OK) &&
		((state_q == S_DECODE && !is_digit) || (state_q == S_END && last_q));

	always_comb begin
		do_reduce = 1'b0;
		case (mode_q)
			M_FINAL: do_reduce = 1'b1;
			M_CLOSE: do_reduce = (op_top_q != OPC_PAREN);
			M_OPER:  do_reduce = (prec(op_top_q) >= prec(new_op_q));
			default: do_reduce = 1'b0;
		endcase
	end

	// Value stack ports: a flushed number, or a reduction result over the
	// lower operand.
	always_comb begin
		v_we    = 1'b0;
		v_waddr = vc_q[AW-1:0];
		v_wdata = accum_q;
		if (flush_now && pending_q && !val_full) begin
			v_we = 1'b1;
		end else if (state_q == S_ALU_WAIT && alu_rsp.done) begin
			v_we    = 1'b1;
			v_waddr = vc_m2[AW-1:0];
			v_wdata = alu_rsp.value;
		end
		case (state_q)
			S_RD_B:  v_raddr = vc_m1[AW-1:0];
			S_RD_A:  v_raddr = vc_m2[AW-1:0];
			default: v_raddr = '0;
		endcase
	end

	// Operator stack push: an open parenthesis, or an operator that
	// survived the precedence loop.
	always_comb begin
		o_we    = 1'b0;
		o_wdata = OPC_PAREN;
		if (!op_full) begin
			if (state_q == S_DISPATCH && err_q == ST_OK && char_q == CH_LPAREN) begin
				o_we = 1'b1;
			end else if (state_q == S_OP_TEST && mode_q == M_OPER &&
				(oc_q == '0 || !do_reduce)) begin
				o_we    = 1'b1;
				o_wdata = new_op_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			val_mem[v_waddr] <= v_wdata;
		end
		val_rd_q <= val_mem[v_raddr];
		if (o_we) begin
			op_mem[oc_q[AW-1:0]] <= o_wdata;
		end
		op_top_q <= op_mem[oc_m1[AW-1:0]];
	end

	// The divide check is done here, so the unit only sees legal requests.
	assign alu_req.valid = (state_q == S_EXEC) &&
		!(op_top_q == OPC_DIV && b_q == '0);
	assign alu_req.op = op_top_q;
	assign alu_req.a  = val_rd_q;
	assign alu_req.b  = b_q;

	iee_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_OPER;
			vc_q        <= '0;
			oc_q        <= '0;
			accum_q     <= '0;
			pending_q   <= 1'b0;
			err_q       <= ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end
			// Shared number flush; the push itself is in the memory port.
			if (flush_now) begin
				if (pending_q) begin
					if (val_full) begin
						err_q <= ST_OVERFLOW;
					end else begin
						vc_q <= vc_q + CW'(1);
					end
				end
				pending_q <= 1'b0;
				accum_q   <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (char_valid) begin
						char_q  <= char_code;
						last_q  <= is_last;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (err_q != ST_OK) begin
						state_q <= S_END;
					end else if (is_digit) begin
						accum_q   <= accum_nx;
						pending_q <= 1'b1;
						state_q   <= S_END;
					end else begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					state_q <= S_OP_WAIT;
					if (err_q != ST_OK || char_q == CH_SPACE) begin
						state_q <= S_END;
					end else begin
						case (char_q)
							CH_LPAREN: begin
								if (op_full) begin
									err_q <= ST_OVERFLOW;
								end else begin
									oc_q <= oc_q + CW'(1);
								end
								state_q <= S_END;
							end
							CH_RPAREN: mode_q <= M_CLOSE;
							CH_PLUS: begin
								new_op_q <= OPC_ADD;
								mode_q   <= M_OPER;
							end
							CH_MINUS: begin
								new_op_q <= OPC_SUB;
								mode_q   <= M_OPER;
							end
							CH_STAR: begin
								new_op_q <= OPC_MUL;
								mode_q   <= M_OPER;
							end
							CH_SLASH: begin
								new_op_q <= OPC_DIV;
								mode_q   <= M_OPER;
							end
							default: begin
								err_q   <= ST_MALFORMED;
								state_q <= S_END;
							end
						endcase
					end
				end
				S_OP_WAIT: state_q <= S_OP_TEST;
				S_OP_TEST: begin
					state_q <= S_END;
					if (err_q != ST_OK) begin
						// The closing number overflowed the value stack, so no
						// reduction may follow.
						state_q <= S_FINAL;
					end else if (oc_q == '0 || (mode_q == M_OPER && !do_reduce)) begin
						case (mode_q)
							M_CLOSE: err_q <= ST_MALFORMED;
							M_FINAL: state_q <= S_FINAL;
							default: begin
								if (op_full) begin
									err_q <= ST_OVERFLOW;
								end else begin
									oc_q <= oc_q + CW'(1);
								end
							end
						endcase
					end else if (!do_reduce) begin
						// Matching open parenthesis: discard it.
						oc_q <= oc_m1;
					end else if (op_top_q == OPC_PAREN || vc_q < CW'(2)) begin
						err_q <= ST_MALFORMED;
					end else begin
						state_q <= S_RD_B;
					end
				end
				S_RD_B: state_q <= S_RD_A;
				S_RD_A: begin
					b_q     <= val_rd_q;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (op_top_q == OPC_DIV && b_q == '0) begin
						err_q   <= ST_DIVZERO;
						state_q <= S_END;
					end else begin
						state_q <= S_ALU_WAIT;
					end
				end
				S_ALU_WAIT: begin
					if (alu_rsp.done) begin
						vc_q    <= vc_m1;
						oc_q    <= oc_m1;
						state_q <= S_OP_WAIT;
					end
				end
				S_END: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (err_q != ST_OK) begin
						state_q <= S_FINAL;
					end else begin
						mode_q  <= M_FINAL;
						state_q <= S_OP_WAIT;
					end
				end
				S_FINAL: begin
					if (err_q == ST_OK && vc_q != CW'(1)) begin
						err_q <= ST_MALFORMED;
					end
					state_q <= S_OUT_LOAD;
				end
				S_OUT_LOAD: begin
					// Wait here while an earlier result is still on offer.
					if (!res_valid_q || result_ready) begin
						value_q     <= (err_q == ST_OK) ? val_rd_q : '0;
						status_q    <= err_q;
						res_valid_q <= 1'b1;
						vc_q        <= '0;
						oc_q        <= '0;
						accum_q     <= '0;
						pending_q   <= 1'b0;
						err_q       <= ST_OK;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign char_ready   = (state_q == S_IDLE);
	assign result_valid = res_valid_q;
	assign value        = value_q;
	assign status       = status_q;

endmodule

// ----- rtl/iee_checker.sv -----
// ----------------------------------------------------------------------------
// iee_checker
// Port-level checks of the infix expression evaluator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iee_checker
	import iee_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        char_valid,
	input logic        char_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [31:0] value,
	input logic [1:0]  status
);

	`ASSERT_NEXT(a_res_hold, clk, arst_n, result_valid && !result_ready, result_valid)
	`ASSERT_NEXT(a_res_stable, clk, arst_n, result_valid && !result_ready, $stable(value) && $stable(status))
	`ASSERT_SAME(a_err_zero, clk, arst_n, result_valid && status != ST_OK, value == '0)
	`ASSERT_NEXT(a_busy_after, clk, arst_n, char_valid && char_ready, !char_ready)

endmodule

bind infix_expression_evaluator_unit iee_checker u_iee_checker (.*);

// ----- sim/tb_infix_expression_evaluator_unit.sv -----
// ----------------------------------------------------------------------------
// tb_infix_expression_evaluator_unit
// Drives expressions one character per request into the evaluator, predicts
// value and status with a behavioural two-stack evaluator, and compares each
// result in order, with both sides idling and stalling at random in some runs.
// ----------------------------------------------------------------------------
module tb_infix_expression_evaluator_unit;
	import iee_pkg::*;

	localparam int DEPTH      = STACK_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        char_valid;
	logic        char_ready;
	logic [7:0]  char_code;
	logic        is_last;
	logic        result_valid;
	logic        result_ready;
	logic [31:0] value;
	logic [1:0]  status;

	infix_expression_evaluator_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_code    (char_code),
		.is_last      (is_last),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value),
		.status       (status)
	);

	// The predictor state mirrors the evaluator: two stacks, their counts,
	// the number being built and the first error seen.
	logic [31:0] vals[DEPTH];
	op_code_t    ops[DEPTH];
	int          n_vals;
	int          n_ops;
	logic [31:0] accum;
	logic        pending;
	status_t     err;

	typedef struct {
		logic [31:0] v;
		status_t     s;
	} outcome_t;

	outcome_t    expected_q[$];
	int          errors;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_off;
	longint      cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	function automatic void clear_evaluator();
		n_vals  = 0;
		n_ops   = 0;
		accum   = '0;
		pending = 1'b0;
		err     = ST_OK;
	endfunction

	function automatic void raise(input status_t s);
		if (err == ST_OK)
			err = s;
	endfunction

	function automatic void push_val(input logic [31:0] v);
		if (n_vals >= DEPTH)
			raise(ST_OVERFLOW);
		else begin
			vals[n_vals] = v;
			n_vals++;
		end
	endfunction

	function automatic void push_opc(input op_code_t o);
		if (n_ops >= DEPTH)
			raise(ST_OVERFLOW);
		else begin
			ops[n_ops] = o;
			n_ops++;
		end
	endfunction

	function automatic int rank(input op_code_t o);
		if (o == OPC_ADD || o == OPC_SUB)
			return 1;
		if (o == OPC_MUL || o == OPC_DIV)
			return 2;
		return 0;
	endfunction

	// Applies the operator on the top of the operator stack.
	function automatic void apply_top();
		op_code_t    o;
		logic [31:0] a, b, r, ma, mb, q;
		o = ops[n_ops-1];
		if (o == OPC_PAREN || n_vals < 2) begin
			raise(ST_MALFORMED);
			return;
		end
		b = vals[n_vals-1];
		a = vals[n_vals-2];
		case (o)
			OPC_ADD: r = a + b;
			OPC_SUB: r = a - b;
			OPC_MUL: r = a * b;
			default: begin
				if (b == 0) begin
					raise(ST_DIVZERO);
					return;
				end
				// Truncating division built on magnitudes, so that the most
				// negative value over minus one wraps back to itself.
				ma = a[31] ? -a : a;
				mb = b[31] ? -b : b;
				q  = ma / mb;
				r  = (a[31] ^ b[31]) ? -q : q;
			end
		endcase
		n_ops--;
		n_vals -= 2;
		push_val(r);
	endfunction

	function automatic void flush_accum();
		if (pending)
			push_val(accum);
		pending = 1'b0;
		accum   = '0;
	endfunction

	function automatic void eval_char(input logic [7:0] c);
		op_code_t o;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			accum   = accum * 10 + 32'(c - CH_ZERO);
			pending = 1'b1;
			return;
		end
		flush_accum();
		if (err != ST_OK || c == CH_SPACE)
			return;
		case (c)
			CH_LPAREN: begin
				push_opc(OPC_PAREN);
				return;
			end
			CH_RPAREN: begin
				while (n_ops > 0 && ops[n_ops-1] != OPC_PAREN && err == ST_OK)
					apply_top();
				if (err != ST_OK)
					return;
				if (n_ops == 0)
					raise(ST_MALFORMED);
				else
					n_ops--;
				return;
			end
			CH_PLUS:  o = OPC_ADD;
			CH_MINUS: o = OPC_SUB;
			CH_STAR:  o = OPC_MUL;
			CH_SLASH: o = OPC_DIV;
			default: begin
				raise(ST_MALFORMED);
				return;
			end
		endcase
		while (n_ops > 0 && err == ST_OK && rank(ops[n_ops-1]) >= rank(o))
			apply_top();
		if (err == ST_OK)
			push_opc(o);
	endfunction

	// Predicts one accepted character; the last one queues an outcome.
	function automatic void predict(input logic [7:0] c, input logic last);
		outcome_t e;
		if (err == ST_OK)
			eval_char(c);
		if (!last)
			return;
		if (err == ST_OK)
			flush_accum();
		while (n_ops > 0 && err == ST_OK)
			apply_top();
		if (err == ST_OK && n_vals != 1)
			raise(ST_MALFORMED);
		e.s = err;
		e.v = (err == ST_OK) ? vals[0] : '0;
		expected_q.push_back(e);
		clear_evaluator();
	endfunction

	// Sends one character and waits for it to be accepted. Valid stays high
	// afterwards so that the next character can follow at once; it is dropped
	// while the sender idles or waits for the results to drain.
	task automatic send_char(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_code  <= c;
		is_last    <= last;
		@(posedge clk);
		while (!char_ready)
			@(posedge clk);
		predict(c, last);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	// Hold-off count: while it runs down the receiver takes nothing.
	always @(posedge clk) begin
		if (hold_off > 0)
			hold_off <= hold_off - 1;
	end

	// Receiver: stalls at random, or holds off entirely while the hold-off
	// count runs, and checks every result it takes.
	always @(posedge clk) begin
		outcome_t e;
		if (result_valid && result_ready) begin
			if (expected_q.size() == 0)
				report_mismatch("unexpected result", value, '0);
			else begin
				e = expected_q.pop_front();
				if (status !== e.s)
					report_mismatch("status", 32'(status), 32'(e.s));
				if (value !== e.v)
					report_mismatch("value", value, e.v);
			end
		end
		if (hold_off > 0)
			result_ready <= 1'b0;
		else
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic wait_drained();
		char_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_digit();
		return CH_ZERO + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	// Builds a well-formed expression with random numbers, operators,
	// spaces and parentheses; sometimes a character is corrupted.
	function automatic string build_expr(input int terms);
		string s;
		int    open;
		s    = "";
		open = 0;
		for (int t = 0; t < terms; t++) begin
			if ($urandom_range(3) == 0 && open < 6) begin
				s = {s, string'(CH_LPAREN)};
				open++;
			end
			if ($urandom_range(15) == 0)
				s = {s, "2147483648"};
			else
				for (int d = $urandom_range(1, 4); d > 0; d--)
					s = {s, string'(pick_digit())};
			if ($urandom_range(5) == 0)
				s = {s, " "};
			if (open > 0 && $urandom_range(2) == 0) begin
				s = {s, string'(CH_RPAREN)};
				open--;
			end
			if (t != terms - 1)
				s = {s, string'(pick_op())};
		end
		while (open > 0) begin
			s = {s, string'(CH_RPAREN)};
			open--;
		end
		if ($urandom_range(9) == 0)
			s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255));
		return s;
	endfunction

	task automatic test_directed();
		send_text("0");
		send_text("2147483647+1");
		send_text("2147483648/4294967295");
		send_text("4294967295*4294967295");
		send_text("1+2*3-(4-10)/3");
		send_text(" 7 - 3 - 2 ");
		send_text("-7/2");
		send_text("12345678901234567890");
		send_text("5/0");
		send_text("1 2");
		send_text(" ");
		send_text("(1+2");
		send_text("1+2)");
		send_text("3+*4");
		send_text("2a+3");
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b1);
		send_text("((((((((((((((((((1))))))))))))))))))");
		send_text("1+2*(3+4*(5+6*(7+8*(9+1*(2+3*(4+5*(6+7*(8+9))))))))");
	endtask

	task automatic test_random(input int n_items);
		int    sent;
		string s;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(19) == 0) begin
				// Noise: random bytes, the last one marked as the end.
				for (int i = $urandom_range(1, 6); i > 0; i--) begin
					send_char(8'($urandom_range(255)), i == 1);
					sent++;
				end
			end else begin
				s = build_expr($urandom_range(1, 8));
				send_text(s);
				sent += s.len();
			end
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_off = 3000;
		for (int i = 0; i < 8; i++)
			send_text("6*7");
		wait_drained();
		send_text("100/7");
		wait_drained();
	endtask

	initial begin
		arst_n         = 1'b0;
		char_valid     = 1'b0;
		char_code      = '0;
		is_last        = 1'b0;
		result_ready   = 1'b0;
		errors         = 0;
		cycles         = 0;
		hold_off       = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		clear_evaluator();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_drained();
		test_random(350);
		send_idle_pct = 73;
		test_random(350);
		send_idle_pct  = 0;
		recv_stall_pct = 73;
		test_random(350);
		send_idle_pct = 10;
		recv_stall_pct = 10;
		test_random(350);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_backpressure();

		repeat (100) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
